@@ rtl/core/assert_macros.svh @@
// Assertion helper macros for the core RTL.
// Needs clk_i and rst_ni in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication check.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/core/mips_pkg.sv @@
// Shared types, opcodes and constants of the MIPS-I subset core.
// No dependencies.
package mips_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned NUM_REGS  = 32;
  localparam int unsigned REG_AW    = 5;
  localparam logic [31:0] START_RESET = 32'hBFC0_0000;
  localparam logic [31:0] SEG_MASK    = 32'hF000_0000;
  localparam int unsigned ISOLATE_BIT = 16;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 104;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'b000000;
  localparam logic [5:0] OP_J       = 6'b000010;
  localparam logic [5:0] OP_JAL     = 6'b000011;
  localparam logic [5:0] OP_BEQ     = 6'b000100;
  localparam logic [5:0] OP_BNE     = 6'b000101;
  localparam logic [5:0] OP_ADDI    = 6'b001000;
  localparam logic [5:0] OP_ADDI_U  = 6'b001001;
  localparam logic [5:0] OP_ANDI    = 6'b001100;
  localparam logic [5:0] OP_ORI     = 6'b001101;
  localparam logic [5:0] OP_LUI     = 6'b001111;
  localparam logic [5:0] OP_COP0    = 6'b010000;
  localparam logic [5:0] OP_LB      = 6'b100000;
  localparam logic [5:0] OP_LW      = 6'b100011;
  localparam logic [5:0] OP_SB      = 6'b101000;
  localparam logic [5:0] OP_SH      = 6'b101001;
  localparam logic [5:0] OP_SW      = 6'b101011;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL  = 6'b000000;
  localparam logic [5:0] FN_JR   = 6'b001000;
  localparam logic [5:0] FN_ADDU = 6'b100001;
  localparam logic [5:0] FN_OR   = 6'b100101;
  localparam logic [5:0] FN_SLTU = 6'b101011;

  localparam logic [4:0] COP0_MT     = 5'b00100;
  localparam logic [4:0] CP0_BPC     = 5'd3;
  localparam logic [4:0] CP0_BDA     = 5'd5;
  localparam logic [4:0] CP0_TAR     = 5'd6;
  localparam logic [4:0] CP0_DCIC    = 5'd7;
  localparam logic [4:0] CP0_BDAM    = 5'd9;
  localparam logic [4:0] CP0_BPCM    = 5'd11;
  localparam logic [4:0] CP0_STATUS  = 5'd12;
  localparam logic [4:0] CP0_CAUSE   = 5'd13;
  localparam logic [4:0] REG_RA      = 5'd31;

  typedef enum logic [2:0] {
    ACC_NONE = 3'd0,
    ACC_LW   = 3'd1,
    ACC_LB   = 3'd2,
    ACC_SB   = 3'd3,
    ACC_SH   = 3'd4,
    ACC_SW   = 3'd5
  } acc_kind_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_ALIGN    = 3'd1,
    ERR_OPCODE   = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_COP0     = 3'd4
  } err_code_e;

  typedef struct packed {
    acc_kind_e   kind;
    logic [31:0] addr;
    logic [31:0] data;
    err_code_e   err;
    logic [4:0]  wr_reg;
    logic [31:0] wr_val;
    logic [31:0] npc;
    logic [4:0]  pend_reg;
    logic        pend_byte;
    logic        status_we;
    logic [4:0]  lwb_reg;
    logic [31:0] lwb_val;
  } exec_t;

endpackage

@@ rtl/core/mips_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module mips_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mips_exec.sv @@
// Decode and execute of one instruction against read operands and core state.
// Depends on mips_pkg.
module mips_exec (
  input  logic [31:0]           instr_i,
  input  logic [31:0]           load_data_i,
  input  logic [31:0]           vs_i,
  input  logic [31:0]           vt_i,
  input  logic [31:0]           pc_i,
  input  logic [31:0]           status_i,
  input  logic [2:0]            halted_i,
  input  logic [4:0]            pend_reg_i,
  input  logic                  pend_byte_i,
  output mips_pkg::exec_t       exec_o
);
  import mips_pkg::*;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] se, sum, npc_seq, agen;
  logic        iso;
  exec_t       e;

  assign op      = instr_i[31:26];
  assign rs      = instr_i[25:21];
  assign rt      = instr_i[20:16];
  assign rd      = instr_i[15:11];
  assign sh      = instr_i[10:6];
  assign fn      = instr_i[5:0];
  assign imm     = instr_i[15:0];
  assign se      = {{16{imm[15]}}, imm};
  assign sum     = vs_i + se;
  assign agen    = sum;
  assign npc_seq = pc_i + 32'd4;
  assign iso     = status_i[ISOLATE_BIT];

  always_comb begin
    e           = '0;
    e.kind      = ACC_NONE;
    e.err       = ERR_OK;
    e.npc       = npc_seq;
    if (halted_i != ERR_OK) begin
      e.err = err_code_e'(halted_i);
    end else if (pc_i[1:0] != 2'b00) begin
      e.err = ERR_ALIGN;
    end else begin
      unique case (op)
        OP_SPECIAL: begin
          unique case (fn)
            FN_SLL:  begin e.wr_reg = rd; e.wr_val = vt_i << sh; end
            FN_OR:   begin e.wr_reg = rd; e.wr_val = vs_i | vt_i; end
            FN_SLTU: begin e.wr_reg = rd; e.wr_val = {31'd0, vs_i < vt_i}; end
            FN_ADDU: begin e.wr_reg = rd; e.wr_val = vs_i + vt_i; end
            FN_JR:   e.npc = vs_i;
            default: e.err = ERR_OPCODE;
          endcase
        end
        OP_LUI:   begin e.wr_reg = rt; e.wr_val = {imm, 16'd0}; end
        OP_ORI:   begin e.wr_reg = rt; e.wr_val = vs_i | {16'd0, imm}; end
        OP_ANDI:  begin e.wr_reg = rt; e.wr_val = vs_i & {16'd0, imm}; end
        OP_ADDI_U: begin e.wr_reg = rt; e.wr_val = sum; end
        OP_ADDI: begin
          if ((vs_i[31] == se[31]) && (sum[31] != vs_i[31])) begin
            e.err = ERR_OVERFLOW;
          end else begin
            e.wr_reg = rt;
            e.wr_val = sum;
          end
        end
        OP_J: e.npc = (npc_seq & SEG_MASK) | {4'd0, instr_i[25:0], 2'b00};
        OP_JAL: begin
          e.wr_reg = REG_RA;
          e.wr_val = npc_seq;
          e.npc    = (npc_seq & SEG_MASK) | {4'd0, instr_i[25:0], 2'b00};
        end
        OP_BEQ: if (vs_i == vt_i) e.npc = pc_i + {se[29:0], 2'b00};
        OP_BNE: if (vs_i != vt_i) e.npc = pc_i + {se[29:0], 2'b00};
        OP_LW: begin
          if (!iso) begin
            e.kind     = ACC_LW;
            e.addr     = agen;
            e.pend_reg = rt;
          end
        end
        OP_LB: begin
          e.kind      = ACC_LB;
          e.addr      = agen;
          e.pend_reg  = rt;
          e.pend_byte = 1'b1;
        end
        OP_SB: if (!iso) begin e.kind = ACC_SB; e.addr = agen; e.data = {24'd0, vt_i[7:0]}; end
        OP_SH: if (!iso) begin e.kind = ACC_SH; e.addr = agen; e.data = {16'd0, vt_i[15:0]}; end
        OP_SW: if (!iso) begin e.kind = ACC_SW; e.addr = agen; e.data = vt_i; end
        OP_COP0: begin
          if (rs != COP0_MT) begin
            e.err = ERR_OPCODE;
          end else begin
            case (rd) inside
              CP0_BPC, CP0_BDA, CP0_TAR, CP0_DCIC, CP0_BDAM, CP0_BPCM, CP0_CAUSE: begin
                if (vt_i != 32'd0) e.err = ERR_COP0;
              end
              CP0_STATUS: e.status_we = 1'b1;
              default: ;
            endcase
          end
        end
        default: e.err = ERR_OPCODE;
      endcase
    end

    if (pend_byte_i) begin
      e.lwb_val = {{24{load_data_i[7]}}, load_data_i[7:0]};
    end else begin
      e.lwb_val = load_data_i;
    end
    e.lwb_reg = pend_reg_i;

    if (e.err != ERR_OK) begin
      e.kind      = ACC_NONE;
      e.addr      = '0;
      e.data      = '0;
      e.wr_reg    = '0;
      e.pend_reg  = pend_reg_i;
      e.pend_byte = pend_byte_i;
      e.status_we = 1'b0;
      e.lwb_reg   = '0;
      e.npc       = pc_i;
    end
  end

  assign exec_o = e;

endmodule

@@ rtl/core/mips_r3000_subset_core_step.sv @@
// Top level of the MIPS-I subset core: stream ports, register file RAMs, state.
// Depends on mips_pkg, mips_ram, mips_exec and assert_macros.svh.
//
//  channel   | direction | payload
//  s_axis    | in        | instr_word, load_data
//  m_axis    | out       | fetch_address, access_kind, access_address, store_data, error_code
//  cfg       | in        | start_address
//
// One instruction per cycle unless the output stalls or a write is split. The
// register file sits in two synchronous RAM copies read at accept; results of the
// previous instruction are forwarded. An instruction that writes both a returning
// load and its own result (different registers) is split into two writes: the RAM
// has one write port. Reset clears the register-file valid bits; no clearing pass
// is needed. The output register lets a new transaction in while a result waits.
`include "assert_macros.svh"

module mips_r3000_subset_core_step (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // instr_word[31:0], load_data[63:32]
  input  logic [mips_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // fetch_address[31:0], access_kind[34:32], access_address[66:35],
  // store_data[98:67], error_code[101:99], zero pad
  output logic [mips_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [31:0]                        cfg_data_i
);
  import mips_pkg::*;

  logic        s_acc, s1_adv, need_split, out_free;
  logic        s1_valid_q, ldone_q, m_valid_q, fresh_q;
  logic [31:0] instr_q, ld_q, pc_q, status_q;
  logic [2:0]  halted_q;
  logic [4:0]  pend_reg_q;
  logic        pend_byte_q;
  logic [NUM_REGS-1:0] rf_valid_q;
  logic        rs_ok_q, rt_ok_q;
  logic [4:0]  rs_q, rt_q;
  logic [4:0]  byp_ld_reg_q, byp_wr_reg_q;
  logic [31:0] byp_ld_val_q, byp_wr_val_q;
  logic [31:0] rs_ram, rt_ram, vs, vt;
  logic        ld_we, wr_we, rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic [OUT_TDATA_W-1:0] m_data_q;
  exec_t       ex;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  mips_ram #(.Width(XLEN), .Depth(NUM_REGS)) u_rf_rs (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (s_acc),
    .raddr_i (s_axis_tdata_i[25:21]),
    .rdata_o (rs_ram)
  );

  mips_ram #(.Width(XLEN), .Depth(NUM_REGS)) u_rf_rt (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (s_acc),
    .raddr_i (s_axis_tdata_i[20:16]),
    .rdata_o (rt_ram)
  );

  // operand select: newest write wins, unwritten entries read zero
  always_comb begin
    if (byp_wr_reg_q != 5'd0 && byp_wr_reg_q == rs_q) vs = byp_wr_val_q;
    else if (byp_ld_reg_q != 5'd0 && byp_ld_reg_q == rs_q) vs = byp_ld_val_q;
    else if (rs_ok_q) vs = rs_ram;
    else vs = '0;
    if (byp_wr_reg_q != 5'd0 && byp_wr_reg_q == rt_q) vt = byp_wr_val_q;
    else if (byp_ld_reg_q != 5'd0 && byp_ld_reg_q == rt_q) vt = byp_ld_val_q;
    else if (rt_ok_q) vt = rt_ram;
    else vt = '0;
  end

  mips_exec u_exec (
    .instr_i     (instr_q),
    .load_data_i (ld_q),
    .vs_i        (vs),
    .vt_i        (vt),
    .pc_i        (pc_q),
    .status_i    (status_q),
    .halted_i    (halted_q),
    .pend_reg_i  (pend_reg_q),
    .pend_byte_i (pend_byte_q),
    .exec_o      (ex)
  );

  assign wr_we      = s1_valid_q && (ex.wr_reg != 5'd0);
  assign ld_we      = s1_valid_q && (ex.lwb_reg != 5'd0) && (ex.lwb_reg != ex.wr_reg);
  assign need_split = ld_we && wr_we && !ldone_q;
  assign s1_adv     = s1_valid_q && out_free && !need_split;

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = ex.wr_reg;
    rf_wdata = ex.wr_val;
    if (need_split) begin
      rf_we    = 1'b1;
      rf_waddr = ex.lwb_reg;
      rf_wdata = ex.lwb_val;
    end else if (s1_adv) begin
      if (wr_we) begin
        rf_we = 1'b1;
      end else if (ld_we && !ldone_q) begin
        rf_we    = 1'b1;
        rf_waddr = ex.lwb_reg;
        rf_wdata = ex.lwb_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      ldone_q      <= 1'b0;
      m_valid_q    <= 1'b0;
      fresh_q      <= 1'b1;
      pc_q         <= START_RESET;
      status_q     <= '0;
      halted_q     <= '0;
      pend_reg_q   <= '0;
      pend_byte_q  <= 1'b0;
      rf_valid_q   <= '0;
      byp_ld_reg_q <= '0;
      byp_wr_reg_q <= '0;
    end else begin
      if (rf_we) rf_valid_q[rf_waddr] <= 1'b1;
      if (need_split) ldone_q <= 1'b1;
      else if (s1_adv) ldone_q <= 1'b0;

      if (s_acc) begin
        s1_valid_q   <= 1'b1;
        byp_ld_reg_q <= (s1_adv && ld_we) ? ex.lwb_reg : 5'd0;
        byp_wr_reg_q <= (s1_adv && wr_we) ? ex.wr_reg : 5'd0;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        m_valid_q <= 1'b1;
        halted_q  <= ex.err;
        if (ex.err == ERR_OK) begin
          pc_q        <= ex.npc;
          pend_reg_q  <= ex.pend_reg;
          pend_byte_q <= ex.pend_byte;
          fresh_q     <= 1'b0;
          if (ex.status_we) status_q <= vt;
        end
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_valid_i && fresh_q) pc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      instr_q      <= s_axis_tdata_i[31:0];
      ld_q         <= s_axis_tdata_i[63:32];
      rs_q         <= s_axis_tdata_i[25:21];
      rt_q         <= s_axis_tdata_i[20:16];
      rs_ok_q      <= rf_valid_q[s_axis_tdata_i[25:21]];
      rt_ok_q      <= rf_valid_q[s_axis_tdata_i[20:16]];
      byp_ld_val_q <= ex.lwb_val;
      byp_wr_val_q <= ex.wr_val;
    end
    if (s1_adv) begin
      m_data_q <= {2'b00, ex.err, ex.data, ex.addr, ex.kind, pc_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `ASSERT_IMPL(a_no_r0_write, rf_we, rf_waddr != 5'd0, "write to register zero")
  `ASSERT_IMPL(a_split_has_item, ldone_q, s1_valid_q, "split write without item")
  `ASSERT_CLK(a_halt_sticky, (halted_q != 3'd0) |=> (halted_q == $past(halted_q)),
              "halt code changed")
  `ASSERT_CLK(a_result_out, s1_adv |=> m_axis_tvalid_o, "result lost")

endmodule
